>>> design/gbp_pkg.sv
// Shared types and constants for the gshare branch predictor.
`timescale 1ns / 1ps
`default_nettype none
package gbp_pkg;

  localparam int IDX_W_DEF  = 14;
  localparam int PC_W       = 32;
  localparam int CTR_W      = 2;
  localparam int HIST_LEN_W = 5;

  localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = 5'd14;

  localparam logic [CTR_W-1:0] CTR_MIN     = 2'd0;
  localparam logic [CTR_W-1:0] CTR_WEAK_NT = 2'd1;
  localparam logic [CTR_W-1:0] CTR_MAX     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // lookup transfer taken this cycle, table read issued
    logic exec;    // table read data valid: report and update
    logic clear;   // initialization sweep writes one entry
  } gbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // sweep is on its final entry
  } gbp_status_t;

endpackage
`default_nettype wire

>>> design/gshare_branch_predictor_top.sv
// Top level of the gshare branch predictor with 2-bit saturating counters.
`timescale 1ns / 1ps
`default_nettype none
// A request transfer happens at a rising edge with start high and busy low; in_mode selects
// predict (0) or train (1), in_pc is the branch address and in_outcome the actual direction
// for training. The table is indexed by the low IDX_W bits of the address XOR the global
// history. Every request returns one result: out_predict_taken is the counter's upper bit as
// read before any update, shown for exactly one cycle while out_valid is high. The receiver
// cannot stall, so it must take the result in that cycle. In the controller a request is a table
// read followed by report and write-back, so busy stays high during the write-back step and a
// new request is taken only after it; the result is registered from the read data in the
// write-back step and then shown with out_valid. The history dependence between consecutive
// training requests and the registered read of the single-port-per-direction counter table
// set this sequence. After reset the block sweeps the table once, writing weakly-not-taken
// into each of the 2^IDX_W entries one per cycle; busy is high throughout.
// The history length register is written by a transfer on the cfg channel, which is always
// ready; writes are to be made while no request is in flight, and a new length applies from
// the next training update.
module gshare_branch_predictor_top #(
  parameter int IDX_W = gbp_pkg::IDX_W_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_mode,
  input  wire logic [gbp_pkg::PC_W-1:0]       in_pc,
  input  wire logic                           in_outcome,
  output logic                                out_valid,
  output logic                                out_predict_taken,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gbp_pkg::HIST_LEN_W-1:0] cfg_data
);

  gbp_pkg::gbp_cmd_t    cmd;
  gbp_pkg::gbp_status_t status;

  // The length register can take a write in any cycle.
  assign cfg_ready = 1'b1;

  gbp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  gbp_dp #(
    .IDX_W(IDX_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_mode          (in_mode),
    .in_pc            (in_pc),
    .in_outcome       (in_outcome),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_predict_taken(out_predict_taken)
  );

endmodule
`default_nettype wire

>>> design/gbp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module gbp_ram #(
  parameter int WIDTH  = 2,
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> design/gbp_ctrl.sv
// Controller state machine: table initialization sweep, lookup and update sequencing.
`timescale 1ns / 1ps
`default_nettype none
module gbp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire gbp_pkg::gbp_status_t status,
  output gbp_pkg::gbp_cmd_t         cmd,
  output logic                      busy
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.accept = (state_r == ST_IDLE) && start;
  assign cmd.exec   = (state_r == ST_EXEC);
  assign cmd.clear  = (state_r == ST_CLEAR);
  assign busy       = (state_r != ST_IDLE);

endmodule
`default_nettype wire

>>> design/gbp_dp.sv
// Datapath: history, index hashing, counter table, saturating update and result register.
`timescale 1ns / 1ps
`default_nettype none
module gbp_dp #(
  parameter int IDX_W = gbp_pkg::IDX_W_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gbp_pkg::gbp_cmd_t                 cmd,
  output gbp_pkg::gbp_status_t                   status,
  input  wire logic                              in_mode,
  input  wire logic [gbp_pkg::PC_W-1:0]          in_pc,
  input  wire logic                              in_outcome,
  input  wire logic                              cfg_wr,
  input  wire logic [gbp_pkg::HIST_LEN_W-1:0]    cfg_data,
  output logic                                   out_valid,
  output logic                                   out_predict_taken
);

  localparam int DEPTH = 1 << IDX_W;

  logic [gbp_pkg::HIST_LEN_W-1:0] hist_len_r;
  logic [IDX_W-1:0]               hist_r;
  logic [IDX_W-1:0]               hist_nxt;
  logic [IDX_W-1:0]               hist_mask;
  logic [IDX_W-1:0]               hist_shift;
  logic [IDX_W-1:0]               idx_r;
  logic [IDX_W-1:0]               idx_nxt;
  logic [IDX_W-1:0]               clr_addr_r;
  logic                           mode_r;
  logic                           outcome_r;
  logic                           out_valid_r;
  logic                           out_taken_r;

  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [gbp_pkg::CTR_W-1:0]      ram_wdata;
  logic [gbp_pkg::CTR_W-1:0]      ram_rdata;
  logic [gbp_pkg::CTR_W-1:0]      ctr_upd;

  assign idx_nxt = in_pc[IDX_W-1:0] ^ hist_r;

  gbp_ram #(
    .WIDTH (gbp_pkg::CTR_W),
    .DEPTH (DEPTH),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (cmd.accept),
    .rd_addr(idx_nxt),
    .rd_data(ram_rdata)
  );

  // Saturating counter step toward the outcome.
  always_comb begin
    ctr_upd = ram_rdata;
    if (outcome_r) begin
      if (ram_rdata != gbp_pkg::CTR_MAX) begin
        ctr_upd = ram_rdata + 2'd1;
      end
    end else begin
      if (ram_rdata != gbp_pkg::CTR_MIN) begin
        ctr_upd = ram_rdata - 2'd1;
      end
    end
  end

  always_comb begin
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = gbp_pkg::CTR_WEAK_NT;
    end else begin
      ram_we    = cmd.exec && mode_r;
      ram_waddr = idx_r;
      ram_wdata = ctr_upd;
    end
  end

  // Bit i of the history survives when i is below the configured length.
  always_comb begin
    for (int i = 0; i < IDX_W; i++) begin
      hist_mask[i] = ({1'b0, hist_len_r} > 6'(i));
    end
  end

  assign hist_shift = IDX_W'({hist_r, outcome_r});
  assign hist_nxt   = hist_shift & hist_mask;

  assign status.clear_last = (clr_addr_r == {IDX_W{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r  <= gbp_pkg::HIST_LEN_RESET;
      hist_r      <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        hist_len_r <= cfg_data;
      end
      if (cmd.exec && mode_r) begin
        hist_r <= hist_nxt;
      end
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + IDX_W'(1);
      end
      out_valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r     <= idx_nxt;
      mode_r    <= in_mode;
      outcome_r <= in_outcome;
    end
    if (cmd.exec) begin
      out_taken_r <= ram_rdata[1];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_taken_r;

endmodule
`default_nettype wire

>>> tb/gbp_checker.sv
// Gshare prediction model and result scoreboard for the branch predictor testbench.
`timescale 1ns / 1ps

package gbp_tb_pkg;
  typedef enum logic {
    MODE_PREDICT = 1'b0,
    MODE_TRAIN   = 1'b1
  } req_mode_t;
endpackage

module gbp_checker #(
  parameter int IDX_W = gbp_pkg::IDX_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_mode,
  input  logic [gbp_pkg::PC_W-1:0]       in_pc,
  input  logic                           in_outcome,
  input  logic                           out_valid,
  input  logic                           out_predict_taken,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [gbp_pkg::HIST_LEN_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             checked,
  output int                             trains
);
  import gbp_pkg::*;
  import gbp_tb_pkg::*;

  localparam int DEPTH = 1 << IDX_W;

  logic [CTR_W-1:0]      counters [DEPTH];
  logic [IDX_W-1:0]      history;
  logic [HIST_LEN_W-1:0] hist_len;
  logic                  taken_q [$];

  // Saturating 2-bit counter step toward the actual direction.
  function automatic logic [CTR_W-1:0] trained_counter(logic [CTR_W-1:0] c, logic taken);
    if (taken) begin
      return (c == CTR_MAX) ? c : c + 2'd1;
    end
    return (c == CTR_MIN) ? c : c - 2'd1;
  endfunction

  // Shift the outcome in, then keep only the configured number of bits.
  function automatic logic [IDX_W-1:0] shifted_history(logic [IDX_W-1:0] h,
                                                       logic taken,
                                                       logic [HIST_LEN_W-1:0] len);
    logic [31:0] len_mask;
    logic [31:0] grown;
    len_mask = (32'd1 << len) - 32'd1;
    grown    = (32'(h) << 1) | 32'(taken);
    return IDX_W'(grown & len_mask);
  endfunction

  always @(posedge clk) begin : track
    logic [IDX_W-1:0] idx;
    logic [CTR_W-1:0] ctr;
    logic             want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) counters[i] = CTR_WEAK_NT;
      history  = '0;
      hist_len = HIST_LEN_RESET;
      taken_q.delete();
    end else begin
      // A result leaving now belongs to an earlier request, so check before enqueuing.
      if (out_valid !== 1'b0) begin
        if (taken_q.size() == 0) begin
          $error("result with no request outstanding: predict_taken actual %0b",
                 out_predict_taken);
          fail_count++;
        end else begin
          want = taken_q.pop_front();
          checked++;
          if (out_predict_taken !== want) begin
            $error("predict_taken mismatch: expected %0b, actual %0b", want, out_predict_taken);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) hist_len = cfg_data;
      if (start && !busy) begin
        idx = IDX_W'(in_pc) ^ history;
        ctr = counters[idx];
        taken_q.push_back(ctr[CTR_W-1]);
        if (in_mode == MODE_TRAIN) begin
          counters[idx] = trained_counter(ctr, in_outcome);
          history       = shifted_history(history, in_outcome, hist_len);
          trains++;
        end
      end
    end
    pending = taken_q.size();
  end

endmodule

>>> tb/testbench.sv
// Top level of the gshare branch predictor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import gbp_pkg::*;
  import gbp_tb_pkg::*;

  localparam int IDX_W = IDX_W_DEF;

  // The slowest correct run is the table sweep after reset plus about 1550 requests with
  // gaps between bursts. The limit is about ten times that length.
  localparam int CYCLE_LIMIT      = 300000;
  localparam int RANDOM_PER_PHASE = 170;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  start      = 1'b0;
  logic                  in_mode    = 1'b0;
  logic [PC_W-1:0]       in_pc      = '0;
  logic                  in_outcome = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [HIST_LEN_W-1:0] cfg_data   = '0;
  logic                  busy;
  logic                  out_valid;
  logic                  out_predict_taken;
  logic                  cfg_ready;

  int fail_count;
  int pending;
  int checked;
  int trains;
  int requests;
  int length_writes;
  int cycle_count;

  gshare_branch_predictor_top #(
    .IDX_W(IDX_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_pc            (in_pc),
    .in_outcome       (in_outcome),
    .out_valid        (out_valid),
    .out_predict_taken(out_predict_taken),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // The checker sees the same pins as the block and keeps its own copy of the table.
  gbp_checker #(
    .IDX_W(IDX_W)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_pc            (in_pc),
    .in_outcome       (in_outcome),
    .out_valid        (out_valid),
    .out_predict_taken(out_predict_taken),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked),
    .trains           (trains)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding", cycle_count,
               pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one request at a falling edge and holds it until the block takes it. Busy is
  // a registered output, so its value at the falling edge is the one the next rising edge
  // sees. The task returns at the falling edge after the transfer, with start still high,
  // so a following request keeps start up without lowering it in between.
  task automatic send_request(input req_mode_t mode, input logic [PC_W-1:0] pc,
                              input logic outcome);
    start      <= 1'b1;
    in_mode    <= mode;
    in_pc      <= pc;
    in_outcome <= outcome;
    while (busy !== 1'b0) @(negedge clk);
    @(negedge clk);
    requests++;
  endtask

  // A gap with start low; the payload carries noise meanwhile.
  task automatic idle_cycles(input int n);
    start      <= 1'b0;
    in_mode    <= 1'($urandom_range(0, 1));
    in_pc      <= $urandom();
    in_outcome <= 1'($urandom_range(0, 1));
    repeat (n) @(negedge clk);
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(negedge clk);
  endtask

  // The length register is only written with nothing in flight. Every request produces a
  // result, so an empty scoreboard means the block is idle; a few spare cycles and a check
  // of busy cover the tail of the last request.
  task automatic set_history_length(input logic [HIST_LEN_W-1:0] len);
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    while (cfg_ready !== 1'b1) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    length_writes++;
  endtask

  // Random traffic shaped like a real branch stream: most requests come from a small set of
  // hot branches, each leaning toward one direction, so counters climb to saturation and
  // the history settles into repeating patterns. The rest are arbitrary addresses and
  // directions. Requests come in bursts; most bursts are followed by a gap.
  task automatic run_random_phase(input int count);
    logic [PC_W-1:0] hot_pc [16];
    logic            lean [16];
    logic [PC_W-1:0] pc;
    logic            outcome;
    req_mode_t       mode;
    int              sent;
    int              burst;
    int              slot;
    for (int i = 0; i < 16; i++) begin
      hot_pc[i] = $urandom();
      lean[i]   = 1'($urandom_range(0, 1));
    end
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < count; b++) begin
        if ($urandom_range(0, 99) < 85) begin
          slot    = $urandom_range(0, 15);
          pc      = hot_pc[slot];
          outcome = ($urandom_range(0, 9) < 8) ? lean[slot] : !lean[slot];
        end else begin
          pc      = $urandom();
          outcome = 1'($urandom_range(0, 1));
        end
        mode = ($urandom_range(0, 9) < 6) ? MODE_TRAIN : MODE_PREDICT;
        send_request(mode, pc, outcome);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
    release_start();
  endtask

  initial begin : stimulus
    logic [HIST_LEN_W-1:0] phase_len [9];
    phase_len = '{5'd0, 5'd31, 5'd1, 5'd13, 5'd15, 5'd7,
                  5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 5'd14};

    // Reset is held low from the start and released at a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset length of 14. The first request also waits out the table sweep. Predict
    // requests with the outcome set must leave the state alone, and the train on address
    // zero makes the following predict on address one land on the same entry.
    send_request(MODE_PREDICT, 32'h0000_0000, 1'b0);
    send_request(MODE_PREDICT, 32'hFFFF_FFFF, 1'b1);
    send_request(MODE_TRAIN, 32'h0000_0000, 1'b1);
    send_request(MODE_PREDICT, 32'h0000_0001, 1'b0);
    send_request(MODE_TRAIN, 32'hFFFF_FFFF, 1'b0);
    release_start();

    // Zero history length turns the block into a bimodal predictor, so one address keeps
    // hitting one counter: drive it to strongly taken, then down to strongly not taken.
    set_history_length(5'd0);
    repeat (3) send_request(MODE_TRAIN, 32'h8000_1234, 1'b1);
    send_request(MODE_PREDICT, 32'h8000_1234, 1'b0);
    repeat (4) send_request(MODE_TRAIN, 32'h8000_1234, 1'b0);
    send_request(MODE_PREDICT, 32'h8000_1234, 1'b1);
    release_start();

    // The longest length exceeds the table width; only the low table bits can matter.
    set_history_length(5'd31);
    repeat (5) send_request(MODE_TRAIN, $urandom(), 1'b1);
    send_request(MODE_PREDICT, 32'h0000_0000, 1'b0);
    release_start();

    // Shortening the length keeps the stored history until the next train masks it, so the
    // first predict still sees the long history.
    set_history_length(5'd2);
    send_request(MODE_PREDICT, 32'h0000_0000, 1'b0);
    send_request(MODE_TRAIN, 32'h0000_0000, 1'b1);
    send_request(MODE_PREDICT, 32'h0000_0000, 1'b0);
    release_start();

    // Random phases, each under its own history length.
    foreach (phase_len[p]) begin
      set_history_length(phase_len[p]);
      run_random_phase(RANDOM_PER_PHASE);
    end

    // Drain: every request has its result before the verdict.
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Run covered %0d requests (%0d training) and checked %0d predictions.",
             requests, trains, checked);
    $display("History length was written %0d times, including 0 and 31.", length_writes);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
